// ----- rtl/lzss_pkg.sv -----
// ----------------------------------------------------------------------------
// lzss_pkg: shared definitions of the LZSS stream decoder
// Register indexes, result status codes, token constants and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lzss_pkg;

	// Default sizes
	localparam int HISTORY_DEPTH_DEF = 4096;
	localparam int COUNT_WIDTH_DEF   = 20;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 2'd2;

	// Register reset values and legal ranges
	localparam logic [3:0]  OFF_BITS_RST = 4'd12;
	localparam logic [3:0]  OFF_BITS_MIN = 4'd7;
	localparam logic [3:0]  OFF_BITS_MAX = 4'd12;
	localparam logic [2:0]  LEN_BITS_RST = 3'd4;
	localparam logic [2:0]  LEN_BITS_MIN = 3'd1;
	localparam logic [2:0]  LEN_BITS_MAX = 3'd5;
	localparam logic [19:0] LIMIT_RST    = 20'd100000;

	// Result payload
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int USED_W   = 20;

	localparam logic [STATUS_W-1:0] ST_DATA  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

	// Token assembly
	localparam int SHIFT_W = 18;
	localparam int HELD_W  = 5;
	localparam int OFF_W   = 12;
	localparam int LEN_W   = 5;
	localparam int CNT_W   = 6;

	localparam logic [HELD_W-1:0] LIT_TOKEN_BITS = 5'd9;
	localparam logic [CNT_W-1:0]  MATCH_BIAS     = 6'd3;
	localparam logic [3:0]        BYTE_BITS      = 4'd8;

	// Controller to datapath
	typedef struct packed {
		logic                clr_step;   // write one zero entry of the clear pass
		logic                accept;     // take the input transaction
		logic                bit_step;   // shift one compressed bit into the token
		logic                tok_take;   // capture token fields, clear the token
		logic                emit_lit;   // emit the literal byte
		logic                emit_copy;  // emit one byte of the match copy
		logic                gen_stat;   // produce a status result
		logic [STATUS_W-1:0] stat_code;
		logic                flush;      // release the pending result as last
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_done;       // stream already finished for the offered byte
		logic clr_last;      // clear pass at its final entry
		logic bit_last;      // bit being shifted is the last of the byte
		logic more_bits;     // bits of the current byte remain
		logic bit_complete;  // this bit completes a token
		logic tok_flag;      // completed token is a literal
		logic limit_hit;     // output count at or over the limit
		logic off_zero;      // match offset is zero
		logic len_zero;      // match length field is zero
		logic emit_limit;    // the byte emitted now reaches the limit
		logic copy_last;     // one byte of the match left
		logic gen_ok;        // a new result can enter the pending stage
		logic pend_valid;    // pending result held
		logic out_free;      // output register can load this cycle
	} sts_t;

endpackage

// ----- rtl/lzss_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzss_ctrl: decoder sequencer
// Steps through the ring clear after reset, then per compressed byte: accept,
// bit-by-bit shifting, token decode, literal or match copy, status results and
// the final release of the last result of the byte.
// ----------------------------------------------------------------------------
module lzss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lzss_pkg::sts_t  sts,
	output lzss_pkg::cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_CLEAR = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_BIT   = 11'b000_0000_0100,
		S_TOKEN = 11'b000_0000_1000,
		S_LIT   = 11'b000_0001_0000,
		S_PRIME = 11'b000_0010_0000,
		S_COPY  = 11'b000_0100_0000,
		S_END   = 11'b000_1000_0000,
		S_LIMIT = 11'b001_0000_0000,
		S_BAD   = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_tok;

	// State after a token is done: more bits of the byte, or wrap up
	assign after_tok = sts.more_bits ? S_BIT : S_FIN;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (!sts.in_done) begin
						state_d = S_BIT;
					end
				end
			end
			S_BIT: begin
				cmd.bit_step = 1'b1;
				if (sts.bit_complete) begin
					state_d = S_TOKEN;
				end else if (sts.bit_last) begin
					state_d = S_FIN;
				end
			end
			S_TOKEN: begin
				cmd.tok_take = 1'b1;
				if (sts.limit_hit) begin
					state_d = S_LIMIT;
				end else if (sts.tok_flag) begin
					state_d = S_LIT;
				end else if (sts.off_zero) begin
					state_d = sts.len_zero ? S_END : S_BAD;
				end else begin
					state_d = S_PRIME;
				end
			end
			S_LIT: begin
				if (sts.gen_ok) begin
					cmd.emit_lit = 1'b1;
					state_d      = sts.emit_limit ? S_LIMIT : after_tok;
				end
			end
			S_PRIME: begin
				state_d = S_COPY;
			end
			S_COPY: begin
				if (sts.gen_ok) begin
					cmd.emit_copy = 1'b1;
					if (sts.emit_limit) begin
						state_d = S_LIMIT;
					end else if (sts.copy_last) begin
						state_d = after_tok;
					end
				end
			end
			S_END: begin
				cmd.stat_code = lzss_pkg::ST_END;
				if (sts.gen_ok) begin
					cmd.gen_stat = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_LIMIT: begin
				cmd.stat_code = lzss_pkg::ST_LIMIT;
				if (sts.gen_ok) begin
					cmd.gen_stat = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_BAD: begin
				cmd.stat_code = lzss_pkg::ST_BAD;
				if (sts.gen_ok) begin
					cmd.gen_stat = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.pend_valid || sts.out_free) begin
					cmd.flush = sts.pend_valid;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// A status result always closes the byte
	a_stat_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_END || state_q == S_LIMIT || state_q == S_BAD) && sts.gen_ok)
		|=> (state_q == S_FIN))
		else $error("status result not followed by byte wrap-up");

	// The read issued while priming lands before the first copy
	a_prime_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRIME) |=> (state_q == S_COPY))
		else $error("match prime not followed by copy");

	// A byte of a finished stream leaves no work behind
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.in_done) |=> (state_q == S_IDLE))
		else $error("byte of finished stream started decoding");

endmodule

// ----- rtl/lzss_dpath.sv -----
// ----------------------------------------------------------------------------
// lzss_dpath: decoder datapath
// Configuration registers, token shifter, stream counters, history ring with
// a registered read port and write bypass, and the pending and output result
// registers.
// ----------------------------------------------------------------------------
module lzss_dpath #(
	parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF,
	parameter int COUNT_WIDTH   = lzss_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lzss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lzss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [lzss_pkg::BYTE_W-1:0]       in_byte,
	input  logic                              stream_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lzss_pkg::BYTE_W-1:0]       out_byte,
	output logic [lzss_pkg::STATUS_W-1:0]     status,
	output logic                              last,
	output logic [lzss_pkg::USED_W-1:0]       bytes_used,
	input  lzss_pkg::cmd_t                    cmd,
	output lzss_pkg::sts_t                    sts
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CMP_W = (COUNT_WIDTH > lzss_pkg::CFG_DATA_W) ? COUNT_WIDTH
		: lzss_pkg::CFG_DATA_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Configuration
	logic [3:0]                        off_bits_q;
	logic [2:0]                        len_bits_q;
	logic [lzss_pkg::CFG_DATA_W-1:0]   limit_q;

	// Stream state
	logic [lzss_pkg::SHIFT_W-1:0]      token_shift_q;
	logic [lzss_pkg::HELD_W-1:0]       held_q;
	logic                              flag_q;
	logic [lzss_pkg::BYTE_W-1:0]       byte_q;
	logic [3:0]                        bits_left_q;
	logic [IDX_W-1:0]                  write_index_q;
	logic [COUNT_WIDTH-1:0]            output_count_q;
	logic [COUNT_WIDTH-1:0]            input_count_q;
	logic                              stream_done_q;

	// Token fields
	logic [lzss_pkg::BYTE_W-1:0]       lit_q;
	logic [IDX_W-1:0]                  off_q;
	logic [lzss_pkg::CNT_W-1:0]        cnt_q;

	// Clear pass
	logic [IDX_W-1:0]                  clr_q;

	// History ring
	logic [lzss_pkg::BYTE_W-1:0]       ring_q [HISTORY_DEPTH];
	logic [lzss_pkg::BYTE_W-1:0]       rd_q;
	logic                              byp_hit_q;
	logic [lzss_pkg::BYTE_W-1:0]       byp_data_q;

	// Results
	logic                              pend_valid_q;
	logic [lzss_pkg::BYTE_W-1:0]       pend_byte_q;
	logic [lzss_pkg::STATUS_W-1:0]     pend_status_q;
	logic [lzss_pkg::USED_W-1:0]       pend_used_q;
	logic                              out_valid_q;
	logic [lzss_pkg::BYTE_W-1:0]       out_byte_q;
	logic [lzss_pkg::STATUS_W-1:0]     out_status_q;
	logic                              out_last_q;
	logic [lzss_pkg::USED_W-1:0]       out_used_q;

	// Combinational
	logic [3:0]                        ob;
	logic [2:0]                        lb;
	logic [lzss_pkg::HELD_W-1:0]       thr;
	logic [lzss_pkg::SHIFT_W-1:0]      shift_nx;
	logic [lzss_pkg::HELD_W-1:0]       held_nx;
	logic                              flag_nx;
	logic                              complete;
	logic [lzss_pkg::LEN_W-1:0]        len_mask;
	logic [lzss_pkg::LEN_W-1:0]        tok_len;
	logic [lzss_pkg::SHIFT_W-1:0]      off_sh;
	logic [lzss_pkg::OFF_W-1:0]        off_mask;
	logic [lzss_pkg::OFF_W-1:0]        tok_off;
	logic [COUNT_WIDTH-1:0]            count_inc;
	logic [COUNT_WIDTH-1:0]            in_base;
	logic                              in_done;
	logic                              emit;
	logic                              gen;
	logic                              out_free;
	logic                              load_out;
	logic [lzss_pkg::BYTE_W-1:0]       rd_data;
	logic [lzss_pkg::BYTE_W-1:0]       emit_data;
	logic [IDX_W-1:0]                  wi_d;
	logic [IDX_W-1:0]                  raddr;
	logic                              mem_we;
	logic [IDX_W-1:0]                  mem_waddr;
	logic [lzss_pkg::BYTE_W-1:0]       mem_wdata;
	logic [lzss_pkg::BYTE_W-1:0]       new_byte;
	logic [lzss_pkg::STATUS_W-1:0]     new_status;
	logic [lzss_pkg::USED_W-1:0]       new_used;

	// Saturate field widths into their legal ranges
	always_comb begin
		ob = off_bits_q;
		if (ob < lzss_pkg::OFF_BITS_MIN) begin
			ob = lzss_pkg::OFF_BITS_MIN;
		end else if (ob > lzss_pkg::OFF_BITS_MAX) begin
			ob = lzss_pkg::OFF_BITS_MAX;
		end
		lb = len_bits_q;
		if (lb < lzss_pkg::LEN_BITS_MIN) begin
			lb = lzss_pkg::LEN_BITS_MIN;
		end else if (lb > lzss_pkg::LEN_BITS_MAX) begin
			lb = lzss_pkg::LEN_BITS_MAX;
		end
	end

	assign thr = lzss_pkg::HELD_W'(1) + lzss_pkg::HELD_W'(ob) + lzss_pkg::HELD_W'(lb);

	// Shift the next bit in; the flag is the oldest held bit
	assign shift_nx = {token_shift_q[lzss_pkg::SHIFT_W-2:0], byte_q[lzss_pkg::BYTE_W-1]};
	assign held_nx  = held_q + 1'b1;
	assign flag_nx  = shift_nx[held_q];
	assign complete = flag_nx ? (held_nx >= lzss_pkg::LIT_TOKEN_BITS) : (held_nx >= thr);

	// Take the match fields from the newest bits
	assign len_mask = lzss_pkg::LEN_W'((6'd1 << lb) - 6'd1);
	assign tok_len  = token_shift_q[lzss_pkg::LEN_W-1:0] & len_mask;
	assign off_sh   = token_shift_q >> lb;
	assign off_mask = lzss_pkg::OFF_W'((13'd1 << ob) - 13'd1);
	assign tok_off  = off_sh[lzss_pkg::OFF_W-1:0] & off_mask;

	// Counters
	assign count_inc = (output_count_q == COUNT_MAX) ? output_count_q
		: output_count_q + 1'b1;
	assign in_base   = stream_start ? '0 : input_count_q;
	assign in_done   = !stream_start && stream_done_q;

	// Result staging
	assign emit      = cmd.emit_lit | cmd.emit_copy;
	assign gen       = emit | cmd.gen_stat;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = (gen || cmd.flush) && pend_valid_q;
	assign rd_data   = byp_hit_q ? byp_data_q : rd_q;
	assign emit_data = cmd.emit_copy ? rd_data : lit_q;

	assign new_byte   = cmd.gen_stat ? '0 : emit_data;
	assign new_status = cmd.gen_stat ? cmd.stat_code : lzss_pkg::ST_DATA;
	assign new_used   = (cmd.gen_stat && cmd.stat_code == lzss_pkg::ST_END)
		? lzss_pkg::USED_W'(input_count_q) : '0;

	// Ring ports: read always follows the next write position minus offset
	always_comb begin
		wi_d = write_index_q;
		if (cmd.accept && stream_start) begin
			wi_d = '0;
		end else if (emit) begin
			wi_d = write_index_q + 1'b1;
		end
	end

	assign raddr     = wi_d - off_q;
	assign mem_we    = cmd.clr_step | emit;
	assign mem_waddr = cmd.clr_step ? clr_q : write_index_q;
	assign mem_wdata = cmd.clr_step ? '0 : emit_data;

	// Status to the controller
	always_comb begin
		sts              = '0;
		sts.in_done      = in_done;
		sts.clr_last     = (clr_q == '1);
		sts.bit_last     = (bits_left_q == 4'd1);
		sts.more_bits    = (bits_left_q != 4'd0);
		sts.bit_complete = complete;
		sts.tok_flag     = flag_q;
		sts.limit_hit    = CMP_W'(output_count_q) >= CMP_W'(limit_q);
		sts.off_zero     = (tok_off == '0);
		sts.len_zero     = (tok_len == '0);
		sts.emit_limit   = CMP_W'(count_inc) >= CMP_W'(limit_q);
		sts.copy_last    = (cnt_q == lzss_pkg::CNT_W'(1));
		sts.gen_ok       = !pend_valid_q || out_free;
		sts.pend_valid   = pend_valid_q;
		sts.out_free     = out_free;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_bits_q <= lzss_pkg::OFF_BITS_RST;
			len_bits_q <= lzss_pkg::LEN_BITS_RST;
			limit_q    <= lzss_pkg::LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lzss_pkg::CFG_OFFSET_BITS:  off_bits_q <= cfg_data[3:0];
				lzss_pkg::CFG_LENGTH_BITS:  len_bits_q <= cfg_data[2:0];
				lzss_pkg::CFG_OUTPUT_LIMIT: limit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stream state: the commands never coincide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_shift_q  <= '0;
			held_q         <= '0;
			flag_q         <= 1'b0;
			byte_q         <= '0;
			bits_left_q    <= '0;
			write_index_q  <= '0;
			output_count_q <= '0;
			input_count_q  <= '0;
			stream_done_q  <= 1'b0;
			lit_q          <= '0;
			off_q          <= '0;
			cnt_q          <= '0;
			clr_q          <= '0;
		end else begin
			write_index_q <= wi_d;
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept) begin
				if (stream_start) begin
					token_shift_q  <= '0;
					held_q         <= '0;
					output_count_q <= '0;
					stream_done_q  <= 1'b0;
				end
				// a byte of a finished stream leaves the count as it is
				if (!in_done) begin
					input_count_q <= (in_base == COUNT_MAX) ? in_base : in_base + 1'b1;
					byte_q        <= in_byte;
					bits_left_q   <= lzss_pkg::BYTE_BITS;
				end
			end
			if (cmd.bit_step) begin
				token_shift_q <= shift_nx;
				held_q        <= complete ? '0 : held_nx;
				flag_q        <= flag_nx;
				byte_q        <= byte_q << 1;
				bits_left_q   <= bits_left_q - 1'b1;
			end
			if (cmd.tok_take) begin
				lit_q         <= token_shift_q[lzss_pkg::BYTE_W-1:0];
				off_q         <= tok_off[IDX_W-1:0];
				cnt_q         <= lzss_pkg::CNT_W'(tok_len) + lzss_pkg::MATCH_BIAS;
				token_shift_q <= '0;
			end
			if (emit) begin
				output_count_q <= count_inc;
			end
			if (cmd.emit_copy) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.gen_stat) begin
				stream_done_q <= 1'b1;
			end
		end
	end

	// History ring: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= ring_q[raddr];
	end

	// Forward a byte written in the same cycle as its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q  <= 1'b0;
			byp_data_q <= '0;
		end else begin
			byp_hit_q  <= mem_we && (mem_waddr == raddr);
			byp_data_q <= mem_wdata;
		end
	end

	// Pending result waits until the next one shows whether it is last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q  <= 1'b0;
			pend_byte_q   <= '0;
			pend_status_q <= lzss_pkg::ST_DATA;
			pend_used_q   <= '0;
			out_valid_q   <= 1'b0;
			out_byte_q    <= '0;
			out_status_q  <= lzss_pkg::ST_DATA;
			out_last_q    <= 1'b0;
			out_used_q    <= '0;
		end else begin
			if (gen) begin
				pend_valid_q  <= 1'b1;
				pend_byte_q   <= new_byte;
				pend_status_q <= new_status;
				pend_used_q   <= new_used;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q  <= 1'b1;
				out_byte_q   <= pend_byte_q;
				out_status_q <= pend_status_q;
				out_last_q   <= cmd.flush;
				out_used_q   <= pend_used_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign status     = out_status_q;
	assign last       = out_last_q;
	assign bytes_used = out_used_q;

	// Pending result holds while the output transaction stalls
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_q && out_valid_q && out_stall)
		|=> (pend_valid_q && $stable(pend_byte_q) && $stable(pend_status_q)))
		else $error("pending result overwritten under output stall");

	// Each emitted byte advances the write position by one
	a_wi_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (write_index_q == IDX_W'($past(write_index_q) + 1'b1)))
		else $error("write index did not advance on emitted byte");

	// A copy never runs past its length
	a_copy_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_copy |-> (cnt_q != '0))
		else $error("match copy beyond its length");

endmodule

// ----- rtl/lzss_stream_decoder.sv -----
// Sequence: accept a byte, shift in its bits, decode a literal, status or match token and
// emit it (a match is primed, then copies length+3 bytes); release the byte's last result.
// A limit status ends the stream at the output limit. Flow: a live byte keeps in_stall
// high until done (at most one token ends in a byte); bytes of a finished stream are
// taken in idle; output stalls hold the flow. Reset: clears control state, then zeroes
// the history ring one entry per cycle with in_stall high; configuration writes are taken.
// ----------------------------------------------------------------------------
// lzss_stream_decoder: streaming LZSS decompressor
// Reads compressed bytes MSB first, emits literals and match copies from the
// history ring, and reports end marker, output limit and bad offset results.
// ----------------------------------------------------------------------------
module lzss_stream_decoder #(
	parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF,
	parameter int COUNT_WIDTH   = lzss_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lzss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lzss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lzss_pkg::BYTE_W-1:0]       in_byte,
	input  logic                              stream_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lzss_pkg::BYTE_W-1:0]       out_byte,
	output logic [lzss_pkg::STATUS_W-1:0]     status,
	output logic                              last,
	output logic [lzss_pkg::USED_W-1:0]       bytes_used
);

	lzss_pkg::cmd_t cmd;
	lzss_pkg::sts_t sts;

	// Sequencer
	lzss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	lzss_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_byte      (in_byte),
		.stream_start (stream_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.status       (status),
		.last         (last),
		.bytes_used   (bytes_used),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
